// ===== rtl/cba_pkg.sv =====
// ----------------------------------------------------------------------------
// cba_pkg
// Shared types and constants of the chunked bump allocator: field widths,
// result status codes, sequencer states and the result of the shared adder.
// ----------------------------------------------------------------------------
`default_nettype none

package cba_pkg;

    localparam int REQ_W    = 13;  // request element count
    localparam int EB_W     = 7;   // element byte size register
    localparam int TOT_W    = REQ_W + EB_W;  // exact byte total of a request
    localparam int STATUS_W = 2;
    localparam int IDX_O_W  = 4;   // chunk index field on the result port
    localparam int OFF_O_W  = 13;  // byte offset field on the result port
    // Wide enough for a fill level of up to 65536 plus any byte total.
    localparam int SUM_W    = TOT_W + 1;

    localparam logic [EB_W-1:0] EB_RESET = 7'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANT    = 2'd0,
        ST_TOO_BIG  = 2'd1,
        ST_NO_CHUNK = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MUL    = 5'b00010,
        S_SIZE   = 5'b00100,
        S_SEARCH = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    typedef struct packed {
        logic             fit;
        logic [SUM_W-1:0] sum;
    } t_unit_res;

endpackage

`default_nettype wire

// ===== rtl/cba_unit.sv =====
// ----------------------------------------------------------------------------
// cba_unit
// Shared add and compare unit: adds a byte total to a base fill level and
// tells whether the sum still fits in one chunk.
// ----------------------------------------------------------------------------
`default_nettype none

module cba_unit import cba_pkg::*; #(
    parameter int CHUNK_BYTES = 4096
) (
    input  wire logic [SUM_W-1:0] i_base,
    input  wire logic [TOT_W-1:0] i_total,
    output t_unit_res             o_res
);

    logic [SUM_W-1:0] sum;

    assign sum       = i_base + SUM_W'(i_total);
    assign o_res.sum = sum;
    assign o_res.fit = (sum <= SUM_W'(CHUNK_BYTES));

endmodule

`default_nettype wire

// ===== rtl/cba_fill_mem.sv =====
// ----------------------------------------------------------------------------
// cba_fill_mem
// Fill level store with one write and one registered read port. A valid bit
// per entry makes an entry that was never written read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module cba_fill_mem import cba_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 13
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [DW-1:0] o_rd_data
);

    logic [DW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [DW-1:0]    r_rd_data;
    logic             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

// ===== rtl/chunked_bump_allocator_unit.sv =====
// Once a request is taken, its byte total is formed from the element count and
// size and checked against the chunk size; an oversized request is refused
// without a search, any other visits 1 to MAX_CHUNKS chunks. A new request is
// taken only after the last result is taken. The chunk search reads one fill
// level per cycle from the single read port of the fill store, newest first.
// Reset (synchronous, active low) opens chunk 0 only, empties every chunk and
// sets the element size to 4 bytes.
// ----------------------------------------------------------------------------
// chunked_bump_allocator_unit
// Bump allocator over a bounded pool of fixed-size chunks, searched by a
// small sequencer around one shared add and compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

module chunked_bump_allocator_unit import cba_pkg::*; #(
    parameter int CHUNK_BYTES = 4096,
    parameter int MAX_CHUNKS  = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [EB_W-1:0]     i_cfg_data,
    input  wire logic                i_req_valid,
    output logic                     o_req_ready,
    input  wire logic [REQ_W-1:0]    i_req_count,
    output logic                     o_rsp_valid,
    input  wire logic                i_rsp_ready,
    output logic      [STATUS_W-1:0] o_status,
    output logic      [IDX_O_W-1:0]  o_chunk_index,
    output logic      [OFF_O_W-1:0]  o_byte_offset,
    output logic                     o_opened_chunk
);

    localparam int FW   = $clog2(CHUNK_BYTES + 1);
    localparam int IW   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int OW   = $clog2(MAX_CHUNKS + 1);
    localparam int IXW  = (IW > IDX_O_W) ? IW : IDX_O_W;
    localparam int OXW  = (FW > OFF_O_W) ? FW : OFF_O_W;

    t_state           r_state, n_state;
    logic [EB_W-1:0]  r_eb;
    logic [REQ_W-1:0] r_count;
    logic [TOT_W-1:0] r_total, n_total;
    logic [OW-1:0]    r_open, n_open;
    logic [IW-1:0]    r_ptr, n_ptr;
    t_status          r_status, n_status;
    logic [IW-1:0]    r_idx, n_idx;
    logic [FW-1:0]    r_off, n_off;
    logic             r_opened, n_opened;

    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    logic [FW-1:0]    wr_data;
    logic [FW-1:0]    rd_fill;
    logic [SUM_W-1:0] unit_base;
    t_unit_res        unit_res;
    logic [OW-1:0]    open_m1;
    logic [IXW-1:0]   idx_ext;
    logic [OXW-1:0]   off_ext;

    cba_unit #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_unit (
        .i_base  (unit_base),
        .i_total (r_total),
        .o_res   (unit_res)
    );

    cba_fill_mem #(
        .DEPTH (MAX_CHUNKS),
        .AW    (IW),
        .DW    (FW)
    ) u_fill_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (n_ptr),
        .o_rd_data (rd_fill)
    );

    assign open_m1 = r_open - OW'(1);

    // The fill store reads at the next pointer, so in the search state the
    // read data always belongs to the chunk that r_ptr names.
    always_comb begin
        n_state   = r_state;
        n_total   = r_total;
        n_open    = r_open;
        n_ptr     = r_ptr;
        n_status  = r_status;
        n_idx     = r_idx;
        n_off     = r_off;
        n_opened  = r_opened;
        wr_en     = 1'b0;
        wr_addr   = r_ptr;
        wr_data   = unit_res.sum[FW-1:0];
        unit_base = SUM_W'(rd_fill);
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_total = TOT_W'(r_count) * TOT_W'(r_eb);
                n_state = S_SIZE;
            end
            S_SIZE: begin
                unit_base = '0;
                n_status  = ST_GRANT;
                n_idx     = '0;
                n_off     = '0;
                n_opened  = 1'b0;
                n_ptr     = open_m1[IW-1:0];
                if (unit_res.fit) begin
                    n_state = S_SEARCH;
                end else begin
                    n_status = ST_TOO_BIG;
                    n_state  = S_DONE;
                end
            end
            S_SEARCH: begin
                if (unit_res.fit) begin
                    wr_en   = 1'b1;
                    n_idx   = r_ptr;
                    n_off   = rd_fill;
                    n_state = S_DONE;
                end else if (r_ptr == '0) begin
                    if (r_open < OW'(MAX_CHUNKS)) begin
                        wr_en    = 1'b1;
                        wr_addr  = r_open[IW-1:0];
                        wr_data  = r_total[FW-1:0];
                        n_idx    = r_open[IW-1:0];
                        n_opened = 1'b1;
                        n_open   = r_open + OW'(1);
                    end else begin
                        n_status = ST_NO_CHUNK;
                    end
                    n_state = S_DONE;
                end else begin
                    n_ptr = r_ptr - IW'(1);
                end
            end
            S_DONE: begin
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_open  <= OW'(1);
            r_eb    <= EB_RESET;
        end else begin
            r_state <= n_state;
            r_open  <= n_open;
            if (i_cfg_valid) begin
                r_eb <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req_valid) begin
            r_count <= i_req_count;
        end
        r_total  <= n_total;
        r_ptr    <= n_ptr;
        r_status <= n_status;
        r_idx    <= n_idx;
        r_off    <= n_off;
        r_opened <= n_opened;
    end

    assign idx_ext = IXW'(r_idx);
    assign off_ext = OXW'(r_off);

    assign o_cfg_ready    = 1'b1;
    assign o_req_ready    = (r_state == S_IDLE);
    assign o_rsp_valid    = (r_state == S_DONE);
    assign o_status       = r_status;
    assign o_chunk_index  = idx_ext[IDX_O_W-1:0];
    assign o_byte_offset  = off_ext[OFF_O_W-1:0];
    assign o_opened_chunk = r_opened;

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_req_ready && o_rsp_valid))
        else $error("request taken while a result is pending");

    a_open_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_open != '0) && (r_open <= OW'(MAX_CHUNKS)))
        else $error("open chunk count out of range");

    a_open_grants: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_opened_chunk) |-> (o_status == ST_GRANT && o_byte_offset == '0))
        else $error("opened chunk without a grant at offset zero");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_status != ST_GRANT) |->
            (o_chunk_index == '0 && o_byte_offset == '0 && !o_opened_chunk))
        else $error("refused request carries a location");

    a_open_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && $past(r_state) == S_SEARCH) |->
            (r_open == $past(r_open) + OW'(r_opened)))
        else $error("open chunk count moved without opening a chunk");
`endif

endmodule

`default_nettype wire
